/* design/tccw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the text console cell writer.
// No dependencies; the other files, except tccw_ram, refer to this package by scoped names.
package tccw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] TEXT_ATTR    = 8'h0F;
	localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_CHAR, TEXT_ATTR};

	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_SET   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SCROLL,
		ST_TAIL,
		ST_BLANK,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // latch the accepted item
		logic exec;       // apply the item to cursor / store
		logic rd_capture; // capture read data into the result
		logic copy_rd;    // scroll: read cell cnt+COLS, write it to cnt next cycle
		logic blank_wr;   // blank cell cnt
		logic cnt_clr;
		logic emit;       // load the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  wrap;      // current put runs past the last cell
		logic  copy_end;
		logic  blank_end;
		logic  out_busy;
	} dp_stat_t;

endpackage

/* design/tccw_req_if.sv */
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with the console item fields.
// Depends on tccw_pkg for field widths.
interface tccw_req_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     mode;
	logic [tccw_pkg::CHAR_W-1:0]    char_code;
	logic [tccw_pkg::COL_W-1:0]     col;
	logic [tccw_pkg::ROW_W-1:0]     row;

	modport source (output valid, mode, char_code, col, row, input ready);
	modport sink   (input valid, mode, char_code, col, row, output ready);
endinterface

/* design/tccw_rsp_if.sv */
`timescale 1ns / 1ps
// Response channel: valid/ready handshake with cursor and cell fields.
// Depends on tccw_pkg for field widths.
interface tccw_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tccw_pkg::COL_W-1:0]     cursor_col;
	logic [tccw_pkg::ROW_W-1:0]     cursor_row;
	logic [tccw_pkg::CHAR_W-1:0]    cell_char;
	logic [tccw_pkg::CHAR_W-1:0]    cell_attr;
	logic                           did_scroll;

	modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, did_scroll,
		input ready);
	modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, did_scroll,
		output ready);
endinterface

/* design/tccw_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/tccw_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the console: item execution, scroll copy, blanking sweeps.
// Depends on tccw_pkg (state, command and status types).
module tccw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  tccw_pkg::dp_stat_t  stat,
	output tccw_pkg::dp_cmd_t   cmd
);

	tccw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tccw_pkg::ST_INIT: begin
				if (stat.blank_end) state_d = tccw_pkg::ST_IDLE;
			end
			tccw_pkg::ST_IDLE: begin
				if (req_valid) state_d = tccw_pkg::ST_EXEC;
			end
			tccw_pkg::ST_EXEC: begin
				case (stat.mode)
					tccw_pkg::MODE_PUT:   state_d = stat.wrap ? tccw_pkg::ST_SCROLL
					                                          : tccw_pkg::ST_EMIT;
					tccw_pkg::MODE_SET:   state_d = tccw_pkg::ST_EMIT;
					tccw_pkg::MODE_CLEAR: state_d = tccw_pkg::ST_BLANK;
					tccw_pkg::MODE_READ:  state_d = tccw_pkg::ST_RDWAIT;
					default:              state_d = tccw_pkg::ST_EMIT;
				endcase
			end
			tccw_pkg::ST_RDWAIT: state_d = tccw_pkg::ST_EMIT;
			tccw_pkg::ST_SCROLL: begin
				if (stat.copy_end) state_d = tccw_pkg::ST_TAIL;
			end
			tccw_pkg::ST_TAIL: state_d = tccw_pkg::ST_BLANK;
			tccw_pkg::ST_BLANK: begin
				if (stat.blank_end) state_d = tccw_pkg::ST_EMIT;
			end
			tccw_pkg::ST_EMIT: begin
				if (!stat.out_busy) state_d = tccw_pkg::ST_IDLE;
			end
			default: state_d = tccw_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			tccw_pkg::ST_INIT:   cmd.blank_wr = 1'b1;
			tccw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.take  = req_valid;
			end
			tccw_pkg::ST_EXEC: begin
				cmd.exec    = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			tccw_pkg::ST_RDWAIT: cmd.rd_capture = 1'b1;
			tccw_pkg::ST_SCROLL: cmd.copy_rd    = 1'b1;
			tccw_pkg::ST_TAIL:   cmd            = '0; // last copy write drains
			tccw_pkg::ST_BLANK:  cmd.blank_wr   = 1'b1;
			tccw_pkg::ST_EMIT:   cmd.emit       = !stat.out_busy;
			default:             cmd            = '0;
		endcase
	end

endmodule

/* design/tccw_dp.sv */
`timescale 1ns / 1ps
// Datapath: item registers, cursor, sweep counter, cell store and output register.
// Depends on tccw_pkg and tccw_ram.
module tccw_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tccw_pkg::dp_cmd_t            cmd,
	output tccw_pkg::dp_stat_t           stat,
	input  logic [1:0]                   in_mode,
	input  logic [tccw_pkg::CHAR_W-1:0]  in_char,
	input  logic [tccw_pkg::COL_W-1:0]   in_col,
	input  logic [tccw_pkg::ROW_W-1:0]   in_row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tccw_pkg::COL_W-1:0]   out_col,
	output logic [tccw_pkg::ROW_W-1:0]   out_row,
	output logic [tccw_pkg::CHAR_W-1:0]  out_char,
	output logic [tccw_pkg::CHAR_W-1:0]  out_attr,
	output logic                         out_scroll
);

	localparam int AW = tccw_pkg::ADDR_W;

	// latched item
	tccw_pkg::mode_t                 mode_q;
	logic [tccw_pkg::CHAR_W-1:0]     char_q;
	logic [tccw_pkg::COL_W-1:0]      itm_col_q;
	logic [tccw_pkg::ROW_W-1:0]      itm_row_q;

	// cursor kept both as col/row and as linear index
	logic [tccw_pkg::COL_W-1:0]      cur_col_q;
	logic [tccw_pkg::ROW_W-1:0]      cur_row_q;
	logic [AW-1:0]                   cur_lin_q;

	logic [AW-1:0]                   cnt_q;
	logic                            copy_pend_q;
	logic [AW-1:0]                   copy_addr_q;

	logic [tccw_pkg::CHAR_W-1:0]     res_char_q, res_attr_q;
	logic                            res_scroll_q;

	logic                            out_valid_q;
	logic [tccw_pkg::COL_W-1:0]      o_col_q;
	logic [tccw_pkg::ROW_W-1:0]      o_row_q;
	logic [tccw_pkg::CHAR_W-1:0]     o_char_q, o_attr_q;
	logic                            o_scroll_q;

	logic [tccw_pkg::COL_W-1:0]      rc;
	logic [tccw_pkg::ROW_W-1:0]      rr;
	logic [AW-1:0]                   itm_addr;
	logic                            is_nl, is_bs, is_put, wrap;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr, ram_raddr;
	logic [tccw_pkg::CELL_W-1:0]     ram_wdata, ram_rdata;

	assign rc = (itm_col_q >= tccw_pkg::COL_W'(tccw_pkg::COLS))
		? tccw_pkg::COL_W'(tccw_pkg::COLS - 1) : itm_col_q;
	assign rr = (itm_row_q >= tccw_pkg::ROW_W'(tccw_pkg::ROWS))
		? tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1) : itm_row_q;
	assign itm_addr = AW'(rr) * AW'(tccw_pkg::COLS) + AW'(rc);

	assign is_put = (mode_q == tccw_pkg::MODE_PUT);
	assign is_nl  = (char_q == tccw_pkg::CH_NEWLINE);
	assign is_bs  = (char_q == tccw_pkg::CH_BACKSPACE);
	assign wrap   = is_put && !is_bs && (is_nl
		? (cur_row_q == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1))
		: (cur_lin_q == AW'(tccw_pkg::CELLS - 1)));

	assign stat.mode      = mode_q;
	assign stat.wrap      = wrap;
	assign stat.copy_end  = (cnt_q == AW'(tccw_pkg::CELLS - tccw_pkg::COLS - 1));
	assign stat.blank_end = (cnt_q == AW'(tccw_pkg::CELLS - 1));
	assign stat.out_busy  = out_valid_q && !out_ready;

	// write port: sweeps and item writes never overlap
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = tccw_pkg::BLANK_CELL;
		if (copy_pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_q;
			ram_wdata = ram_rdata;
		end else if (cmd.blank_wr) begin
			ram_we    = 1'b1;
		end else if (cmd.exec && is_put && !is_nl) begin
			if (is_bs) begin
				ram_we    = (cur_lin_q != '0);
				ram_waddr = cur_lin_q - AW'(1);
			end else begin
				ram_we    = 1'b1;
				ram_waddr = cur_lin_q;
				ram_wdata = {char_q, tccw_pkg::TEXT_ATTR};
			end
		end
	end

	assign ram_raddr = cmd.copy_rd ? cnt_q + AW'(tccw_pkg::COLS) : itm_addr;

	tccw_ram #(
		.WIDTH(tccw_pkg::CELL_W),
		.DEPTH(tccw_pkg::CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q    <= tccw_pkg::mode_t'(in_mode);
			char_q    <= in_char;
			itm_col_q <= in_col;
			itm_row_q <= in_row;
		end
		copy_addr_q <= cnt_q;
		if (cmd.take) begin
			res_char_q   <= '0;
			res_attr_q   <= '0;
			res_scroll_q <= 1'b0;
		end else if (cmd.rd_capture) begin
			res_char_q <= ram_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
			res_attr_q <= ram_rdata[tccw_pkg::CHAR_W-1:0];
		end else if (cmd.exec && wrap) begin
			res_scroll_q <= 1'b1;
		end
		if (cmd.emit) begin
			o_col_q    <= cur_col_q;
			o_row_q    <= cur_row_q;
			o_char_q   <= res_char_q;
			o_attr_q   <= res_attr_q;
			o_scroll_q <= res_scroll_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			cur_lin_q   <= '0;
			cnt_q       <= '0;
			copy_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			copy_pend_q <= cmd.copy_rd;
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.copy_rd || cmd.blank_wr) begin
				cnt_q <= cnt_q + AW'(1);
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.exec) begin
				case (mode_q)
					tccw_pkg::MODE_PUT: begin
						if (wrap) begin
							cur_col_q <= '0;
							cur_row_q <= tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
							cur_lin_q <= AW'(tccw_pkg::CELLS - tccw_pkg::COLS);
						end else if (is_nl) begin
							cur_col_q <= '0;
							cur_row_q <= cur_row_q + tccw_pkg::ROW_W'(1);
							cur_lin_q <= cur_lin_q + AW'(tccw_pkg::COLS) - AW'(cur_col_q);
						end else if (is_bs) begin
							if (cur_lin_q != '0) begin
								if (cur_col_q == '0) begin
									cur_col_q <= tccw_pkg::COL_W'(tccw_pkg::COLS - 1);
									cur_row_q <= cur_row_q - tccw_pkg::ROW_W'(1);
								end else begin
									cur_col_q <= cur_col_q - tccw_pkg::COL_W'(1);
								end
								cur_lin_q <= cur_lin_q - AW'(1);
							end
						end else begin
							if (cur_col_q == tccw_pkg::COL_W'(tccw_pkg::COLS - 1)) begin
								cur_col_q <= '0;
								cur_row_q <= cur_row_q + tccw_pkg::ROW_W'(1);
							end else begin
								cur_col_q <= cur_col_q + tccw_pkg::COL_W'(1);
							end
							cur_lin_q <= cur_lin_q + AW'(1);
						end
					end
					tccw_pkg::MODE_SET: begin
						cur_col_q <= rc;
						cur_row_q <= rr;
						cur_lin_q <= itm_addr;
					end
					tccw_pkg::MODE_CLEAR: begin
						cur_col_q <= '0;
						cur_row_q <= '0;
						cur_lin_q <= '0;
					end
					default: begin
						cur_lin_q <= cur_lin_q;
					end
				endcase
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_col    = o_col_q;
	assign out_row    = o_row_q;
	assign out_char   = o_char_q;
	assign out_attr   = o_attr_q;
	assign out_scroll = o_scroll_q;

endmodule

/* design/text_console_cell_writer.sv */
`timescale 1ns / 1ps
// Text console cell writer: 80x25 store of character/attribute cells plus a cursor.
// Channels: req (sink) carries mode, char_code, col, row; rsp (source) returns
// cursor_col, cursor_row, cell_char, cell_attr and did_scroll, one transfer per item.
// One item is in work at a time. Steps from the req transfer to rsp valid:
//   set cursor, plain put, newline, backspace without scroll: execute, then load the result
//   read cell: an extra wait state for the registered RAM read
//   clear screen: all CELLS cells blanked, one per cycle
//   put that scrolls: copy of CELLS-COLS cells, one per cycle through
//   the single-port-pair cell RAM, then COLS cells blanked
// req.ready returns in the cycle after the result is loaded, so the next item is
// taken only after that; the cell RAM port sets the cost of scroll and clear.
// The output register lets the next item be taken and worked on while the
// previous result waits; a stalled rsp holds its payload, and the next result
// waits in the block until the register frees.
// Reset (arst_n low) clears the cursor and control state; afterwards a sweep over
// all CELLS (2000) cells blanks every cell to space with attribute 0x0F, during
// which req.ready stays low.
// Depends on tccw_pkg, tccw_req_if, tccw_rsp_if, tccw_ram, tccw_ctrl, tccw_dp.
module text_console_cell_writer (
	input  logic              clk,
	input  logic              arst_n,
	tccw_req_if.sink          req,
	tccw_rsp_if.source        rsp
);

	tccw_pkg::dp_cmd_t  cmd;
	tccw_pkg::dp_stat_t stat;

	tccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tccw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_mode    (req.mode),
		.in_char    (req.char_code),
		.in_col     (req.col),
		.in_row     (req.row),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_col    (rsp.cursor_col),
		.out_row    (rsp.cursor_row),
		.out_char   (rsp.cell_char),
		.out_attr   (rsp.cell_attr),
		.out_scroll (rsp.did_scroll)
	);

	// one item in work at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item taken while another in work");

	// a scroll always leaves the cursor at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.did_scroll |->
			rsp.cursor_col == '0 &&
			rsp.cursor_row == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1))
		else $error("scroll left cursor off last row start");

	// reported cursor stays on the grid
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |->
			rsp.cursor_col < tccw_pkg::COL_W'(tccw_pkg::COLS) &&
			rsp.cursor_row < tccw_pkg::ROW_W'(tccw_pkg::ROWS))
		else $error("cursor off grid");

	// the scroll copy, the blanking sweep and item execution are never commanded together
	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.copy_rd && cmd.blank_wr) && !(cmd.exec && (cmd.copy_rd || cmd.blank_wr)))
		else $error("overlapping store commands");

endmodule
